/* rtl/core/cpr_pkg.sv */
// ----------------------------------------------------------------------------
// cpr_pkg
// Types and constants of the clock page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpr_pkg;

	localparam int PAGE_COUNT = 64;
	localparam int MAX_FRAMES = 16;
	localparam int PAGE_W     = 6;
	localparam int FRAME_W    = 4;
	localparam int CNT_W      = 5;
	localparam int FAULT_W    = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;
	localparam int PADDR_W    = 3;

	localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(4);
	localparam logic [CNT_W-1:0] FRAMES_MAX   = CNT_W'(MAX_FRAMES);

	// register index, taken from paddr[2]
	localparam logic REG_FRAMES_IN_USE = 1'b0;

	typedef struct packed {
		logic               refd;
		logic               res;
		logic [FRAME_W-1:0] frame;
	} pent_t;

endpackage

`default_nettype wire

/* rtl/core/clock_page_replacement.sv */
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second chance) page replacement engine with a page table memory and
// a frame table memory, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one page reference per transaction, page in s_tdata.
//   Output stream m_*: one result per reference in m_tdata.
//   APB port: register 0 (byte address 0) is frames_in_use; write it only
//   while the block is idle.
// Sequencing:
//   A hit or a fault that fills a free frame passes from S_LOOK to S_OUT.
//   A fault that sweeps passes S_LOOK, then S_FRD and S_PRD once per hand
//   step, then S_WRN and S_OUT; each hand step costs one frame table
//   read followed by one page table read-modify-write.
//   One reference is in work at a time; the next is accepted once the
//   result has moved into the output register.
// Reset:
//   arst_n clears the page table valid bits (all pages not resident, not
//   referenced), the hand, the fill count and the fault counter at once.
// Stall:
//   A result waits in the output register while m_tready is low; the
//   sequencer holds its finished result until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_page_replacement (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// APB configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [cpr_pkg::PADDR_W-1:0]      paddr,
	input  wire logic [31:0]                      pwdata,
	output      logic [31:0]                      prdata,
	output      logic                             pready,
	// input stream
	input  wire logic                             s_tvalid,
	output      logic                             s_tready,
	input  wire logic [cpr_pkg::IN_TDATA_W-1:0]   s_tdata,  // [5:0] page
	// output stream
	output      logic                             m_tvalid,
	input  wire logic                             m_tready,
	// [0] hit, [4:1] frame_index, [5] evicted_valid, [11:6] evicted_page,
	// [27:12] fault_count
	output      logic [cpr_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	import cpr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_FRD,
		S_PRD,
		S_WRN,
		S_OUT
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]   frames_cfg_q;
	logic [CNT_W-1:0]   n_act;
	logic [FRAME_W-1:0] hand_q;
	logic [FRAME_W-1:0] hand_eff;
	logic [FRAME_W-1:0] hand_nxt;
	logic [CNT_W-1:0]   filled_q;
	logic [FAULT_W-1:0] faults_q;
	logic [PAGE_W-1:0]  p_q;
	logic [PAGE_W-1:0]  q_q;

	logic               hit_q;
	logic [FRAME_W-1:0] frame_q;
	logic               evv_q;
	logic [PAGE_W-1:0]  evp_q;
	logic               m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// page table memory with flip-flop valid bits
	pent_t              pmem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] pv_q;
	pent_t              prd_s1;
	logic               pv_s1;
	pent_t              pent;
	logic [PAGE_W-1:0]  pr_addr;
	logic               pw_en;
	logic [PAGE_W-1:0]  pw_addr;
	pent_t              pw_data;

	// frame table memory
	logic [PAGE_W-1:0]  fmem [MAX_FRAMES];
	logic [PAGE_W-1:0]  frd_s1;
	logic [FRAME_W-1:0] fr_addr;
	logic               fw_en;
	logic [FRAME_W-1:0] fw_addr;

	logic               s_acc;
	logic               cfg_wr;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_FRAMES_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= FRAMES_RESET;
		end else if (cfg_wr) begin
			frames_cfg_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_FRAMES_IN_USE) begin
			prdata = {{(32-CNT_W){1'b0}}, frames_cfg_q};
		end
	end

	always_comb begin
		n_act = frames_cfg_q;
		if (frames_cfg_q == '0) begin
			n_act = CNT_W'(1);
		end else if (frames_cfg_q > FRAMES_MAX) begin
			n_act = FRAMES_MAX;
		end
	end

	// ------------------------------------------------------------------
	// hand arithmetic
	// ------------------------------------------------------------------
	assign hand_eff = ({1'b0, hand_q} >= n_act) ? '0 : hand_q;
	assign hand_nxt = (({1'b0, hand_q} + CNT_W'(1)) == n_act) ? '0 : hand_q + FRAME_W'(1);

	// ------------------------------------------------------------------
	// memory ports
	// ------------------------------------------------------------------
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid & s_tready;
	assign pent     = pv_s1 ? prd_s1 : pent_t'('0);

	always_comb begin
		pr_addr = p_q;
		fr_addr = hand_q;
		pw_en   = 1'b0;
		pw_addr = p_q;
		pw_data = '{refd: 1'b1, res: 1'b1, frame: hand_q};
		fw_en   = 1'b0;
		fw_addr = hand_q;
		case (state_q)
			S_IDLE: begin
				pr_addr = s_tdata[PAGE_W-1:0];
			end
			S_LOOK: begin
				fr_addr = hand_eff;
				if (pent.res) begin
					pw_en   = 1'b1;
					pw_data = '{refd: 1'b1, res: 1'b1, frame: pent.frame};
				end else if (filled_q < n_act) begin
					pw_en   = 1'b1;
					pw_data = '{refd: 1'b1, res: 1'b1, frame: filled_q[FRAME_W-1:0]};
					fw_en   = 1'b1;
					fw_addr = filled_q[FRAME_W-1:0];
				end
			end
			S_FRD: begin
				pr_addr = frd_s1;
			end
			S_PRD: begin
				fr_addr = hand_nxt;
				pw_en   = 1'b1;
				pw_addr = q_q;
				if (pent.refd) begin
					pw_data = '{refd: 1'b0, res: pent.res, frame: pent.frame};
				end else begin
					pw_data = '{refd: 1'b0, res: 1'b0, frame: pent.frame};
				end
			end
			S_WRN: begin
				pw_en = 1'b1;
				fw_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			pmem[pw_addr] <= pw_data;
		end
		prd_s1 <= pmem[pr_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			pv_s1 <= 1'b0;
		end else begin
			if (pw_en) begin
				pv_q[pw_addr] <= 1'b1;
			end
			pv_s1 <= pv_q[pr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (fw_en) begin
			fmem[fw_addr] <= p_q;
		end
		frd_s1 <= fmem[fr_addr];
	end

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			hand_q     <= '0;
			filled_q   <= '0;
			faults_q   <= '0;
			p_q        <= '0;
			q_q        <= '0;
			hit_q      <= 1'b0;
			frame_q    <= '0;
			evv_q      <= 1'b0;
			evp_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						p_q     <= s_tdata[PAGE_W-1:0];
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					evv_q <= 1'b0;
					evp_q <= '0;
					if (pent.res) begin
						hit_q   <= 1'b1;
						frame_q <= pent.frame;
						state_q <= S_OUT;
					end else begin
						hit_q <= 1'b0;
						if (faults_q != '1) begin
							faults_q <= faults_q + FAULT_W'(1);
						end
						if (filled_q < n_act) begin
							frame_q  <= filled_q[FRAME_W-1:0];
							filled_q <= filled_q + CNT_W'(1);
							state_q  <= S_OUT;
						end else begin
							hand_q  <= hand_eff;
							state_q <= S_FRD;
						end
					end
				end
				S_FRD: begin
					q_q     <= frd_s1;
					state_q <= S_PRD;
				end
				S_PRD: begin
					if (pent.refd) begin
						hand_q  <= hand_nxt;
						state_q <= S_FRD;
					end else begin
						frame_q <= hand_q;
						evv_q   <= 1'b1;
						evp_q   <= q_q;
						state_q <= S_WRN;
					end
				end
				S_WRN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(OUT_TDATA_W-FAULT_W-PAGE_W-FRAME_W-2){1'b0}},
							faults_q, evp_q, evv_q, frame_q, hit_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_filled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		filled_q <= FRAMES_MAX)
		else $error("fill count beyond frame capacity");

	a_faults_mono: assert property (@(posedge clk) disable iff (!arst_n)
		faults_q >= $past(faults_q))
		else $error("fault counter went backwards");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[5])
		else $error("hit result carries an eviction");

	a_hand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRD) || (state_q == S_PRD) |-> ({1'b0, hand_q} < n_act))
		else $error("clock hand outside managed frames during sweep");

endmodule

`default_nettype wire

/* verif/cpr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpr_checker
// Follows every page reference and every frames_in_use write seen on the
// ports, keeps its own page table, frame table and clock hand, and compares
// each result transaction field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module cpr_checker
	import cpr_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [PADDR_W-1:0]     paddr,
	input  wire logic [31:0]            pwdata,
	input  wire logic                   pready,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [5:0] page
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	// [0] hit, [4:1] frame_index, [5] evicted_valid, [11:6] evicted_page,
	// [27:12] fault_count
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,
	output int                          fails,
	output int                          pending
);

	// packed from the top field down so the layout matches m_tdata
	typedef struct packed {
		logic [FAULT_W-1:0] faults;
		logic [PAGE_W-1:0]  evicted_page;
		logic               evicted;
		logic [FRAME_W-1:0] frame;
		logic               hit;
	} outcome_t;

	outcome_t           outcomes_due [$];
	logic               resident [PAGE_COUNT];
	logic               referenced [PAGE_COUNT];
	logic [FRAME_W-1:0] frame_of_page [PAGE_COUNT];
	logic [PAGE_W-1:0]  page_in_frame [MAX_FRAMES];
	logic [FRAME_W-1:0] hand;
	logic [CNT_W-1:0]   filled;
	logic [FAULT_W-1:0] faults;
	logic [CNT_W-1:0]   frames_cfg;

	initial fails = 0;

	function automatic outcome_t reference_page(input logic [PAGE_W-1:0] pg);
		outcome_t o;
		int n;
		int steps;
		o = '0;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES_MAX) ? MAX_FRAMES : int'(frames_cfg);
		if (resident[pg]) begin
			o.hit = 1'b1;
			o.frame = frame_of_page[pg];
		end else begin
			if (faults != '1)
				faults = faults + 1'b1;
			if (filled < n) begin
				o.frame = filled[FRAME_W-1:0];
				filled = filled + 1'b1;
			end else begin
				if (hand >= n)
					hand = '0;
				// second chance: clear set bits until an unreferenced page turns up
				steps = 0;
				while (referenced[page_in_frame[hand]] && steps <= 2 * n) begin
					referenced[page_in_frame[hand]] = 1'b0;
					hand = FRAME_W'((int'(hand) + 1) % n);
					steps++;
				end
				o.frame = hand;
				o.evicted = 1'b1;
				o.evicted_page = page_in_frame[hand];
				resident[o.evicted_page] = 1'b0;
				referenced[o.evicted_page] = 1'b0;
			end
			page_in_frame[o.frame] = pg;
			frame_of_page[pg] = o.frame;
			resident[pg] = 1'b1;
		end
		referenced[pg] = 1'b1;
		o.faults = faults;
		return o;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			for (int i = 0; i < PAGE_COUNT; i++) begin
				resident[i] = 1'b0;
				referenced[i] = 1'b0;
			end
			hand = '0;
			filled = '0;
			faults = '0;
			frames_cfg = FRAMES_RESET;
			outcomes_due.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES_IN_USE)
				frames_cfg = pwdata[CNT_W-1:0];
			if (m_tvalid && m_tready) begin
				got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
				if (outcomes_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
					fails++;
				end else begin
					want = outcomes_due.pop_front();
					check_field("hit", want.hit, got.hit);
					check_field("frame_index", want.frame, got.frame);
					check_field("evicted_valid", want.evicted, got.evicted);
					check_field("evicted_page", want.evicted_page, got.evicted_page);
					check_field("fault_count", want.faults, got.faults);
				end
			end
			if (s_tvalid && s_tready)
				outcomes_due.push_back(reference_page(s_tdata[PAGE_W-1:0]));
			pending <= outcomes_due.size();
		end
	end

endmodule

/* verif/tb_clock_page_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_page_replacement
// Streams page references into the clock replacement block under several
// frame counts, with random gaps and stalls on both streams, and leaves the
// result checking to cpr_checker.
// ----------------------------------------------------------------------------
module tb_clock_page_replacement;
	import cpr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int TAIL_CYCLES    = 64;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 88;

	logic                   clk;
	logic                   arst_n;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_W-1:0]     paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int   fails;
	int   pending;
	int   quiet;
	logic jitter;
	logic hold_ask;
	logic hold_served;

	clock_page_replacement dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	cpr_checker tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.fails    (fails),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial quiet = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_served = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_ask && !hold_served) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end else if (jitter && $urandom_range(0, 99) < 2) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(15, 60)) @(posedge clk);
			end else begin
				m_tready <= jitter ? ($urandom_range(0, 3) != 0) : 1'b1;
				@(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!jitter || r < 50)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	// leaves tvalid high so back-to-back transactions need no extra edge
	task automatic send_page(input logic [PAGE_W-1:0] pg);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(pg);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_frames(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		drain();
		w = $urandom;
		w[CNT_W-1:0] = v;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_FRAMES_IN_USE, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int n;
		int base;
		int v;
		logic [PAGE_W-1:0] page;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		jitter = 1'b1;
		hold_ask = 1'b0;
		base = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill four frames, hit, then sweeps over fully referenced frames
		send_page(6'd0);
		send_page(6'd63);
		send_page(6'd0);
		send_page(6'd21);
		send_page(6'd42);
		send_page(6'd5);
		send_page(6'd63);
		send_page(6'd7);
		send_page(6'd0);
		// count raised after filling
		set_frames(5'd16);
		send_page(6'd9);
		send_page(6'd10);
		// count lowered: hand past the end, pages above the count still hit
		set_frames(5'd2);
		send_page(6'd9);
		send_page(6'd11);
		send_page(6'd12);
		// zero acts as one, above max acts as max
		set_frames(5'd0);
		send_page(6'd13);
		send_page(6'd14);
		set_frames(5'd31);
		send_page(6'd15);
		send_page(6'd16);
		send_page(6'd9);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: v = 16;
				1: v = 1;
				2: v = 31;
				3: v = 0;
				4: v = 2;
				default: v = $urandom_range(0, 31);
			endcase
			set_frames(CNT_W'(v));
			n = (v == 0) ? 1 : (v > MAX_FRAMES) ? MAX_FRAMES : v;
			jitter <= (ph != 3);
			if (ph == 1)
				hold_ask <= 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 24 == 0)
					base = $urandom_range(0, 63);
				if (ph == 5 && k == PHASE_ITEMS / 2)
					drain();
				// mostly a working set a little larger than the frames
				if ($urandom_range(0, 9) < 7)
					page = PAGE_W'(base + $urandom_range(0, n + 2));
				else
					page = PAGE_W'($urandom_range(0, 63));
				send_page(page);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
